// ===== design/qgp_pkg.sv =====
`default_nettype none
package qgp_pkg;

  // iteration counts of the root and divide pipelines
  localparam int SQRT_ITERS = 32;
  localparam int DIV_ITERS  = 15;

  localparam logic [15:0] STEP_PERIOD_RST = 16'd10486;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] bias_x;
    logic signed [15:0] bias_y;
    logic signed [15:0] bias_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] next_w;
    logic signed [15:0] next_x;
    logic signed [15:0] next_y;
    logic signed [15:0] next_z;
    logic signed [15:0] bias_out_x;
    logic signed [15:0] bias_out_y;
    logic signed [15:0] bias_out_z;
    logic               zero_norm;
  } out_item_t;

  // side data that rides along the pipeline: bias and the unnormalized
  // quaternion as sign and magnitude
  typedef struct packed {
    logic signed [15:0] bias_x;
    logic signed [15:0] bias_y;
    logic signed [15:0] bias_z;
    logic [3:0]         neg;
    logic [3:0][30:0]   mag;
  } carry_t;

endpackage
`default_nettype wire

// ===== design/quaternion_gyro_propagation_core.sv =====
`default_nettype none
// Stages from input accept to out_valid: 6 arithmetic stages, one sum stage,
// 32 square-root stages, one divide setup stage, 15 divide stages and the
// output register. Throughput: one item per cycle; the whole pipeline holds
// while a result waits on out_ready. Synchronous active-low reset clears
// all valid bits and loads step_period with its default.
module quaternion_gyro_propagation_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire qgp_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output qgp_pkg::out_item_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [15:0]       cfg_data
);

  localparam int NS = qgp_pkg::SQRT_ITERS;
  localparam int ND = qgp_pkg::DIV_ITERS;

  logic en;
  logic [15:0] step_period_r;

  // stage registers
  logic v_a_r, v_b_r, v_c_r, v_d_r, v_e_r;
  logic signed [15:0] q_a_r [4];
  logic signed [16:0] c_a_r [3];
  logic signed [15:0] q_b_r [4];
  logic signed [32:0] prod_b_r [4][3];
  logic signed [15:0] q_c_r [4];
  logic signed [34:0] s_c_r [4];
  logic signed [15:0] q_d_r [4];
  logic signed [51:0] m_d_r [4];
  logic [61:0]        sq_f_r [4];
  logic v_f_r;
  qgp_pkg::carry_t car_a_r, car_b_r, car_c_r, car_d_r, car_e_r, car_f_r;

  logic [63:0]     sr_rem_r [NS+1];
  logic [63:0]     sr_res_r [NS+1];
  qgp_pkg::carry_t sr_car_r [NS+1];
  logic            sr_v_r   [NS+1];

  logic [45:0]     dv_rem_r  [4][ND+1];
  logic [14:0]     dv_quo_r  [4][ND+1];
  logic [31:0]     dv_r_r    [ND+1];
  logic            dv_zero_r [ND+1];
  qgp_pkg::carry_t dv_car_r  [ND+1];
  logic            dv_v_r    [ND+1];

  qgp_pkg::out_item_t out_item_r, out_item_nxt;
  logic               out_v_r;

  qgp_pkg::carry_t car_e_nxt;

  assign en        = !out_v_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_v_r;
  assign out_data  = out_item_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_period_r <= qgp_pkg::STEP_PERIOD_RST;
    end else if (cfg_valid) begin
      step_period_r <= cfg_data;
    end
  end

  // valid bits of the fixed stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r     <= 1'b0;
      v_b_r     <= 1'b0;
      v_c_r     <= 1'b0;
      v_d_r     <= 1'b0;
      v_e_r     <= 1'b0;
      v_f_r     <= 1'b0;
      sr_v_r[0] <= 1'b0;
      dv_v_r[0] <= 1'b0;
      out_v_r   <= 1'b0;
    end else if (en) begin
      v_a_r     <= in_valid;
      v_b_r     <= v_a_r;
      v_c_r     <= v_b_r;
      v_d_r     <= v_c_r;
      v_e_r     <= v_d_r;
      v_f_r     <= v_e_r;
      sr_v_r[0] <= v_f_r;
      dv_v_r[0] <= sr_v_r[NS];
      out_v_r   <= dv_v_r[ND];
    end
  end

  // round to 2^-24 half away from zero, saturate, split sign and magnitude
  always_comb begin
    logic signed [53:0] p;
    logic [53:0]        pmag;
    logic [53:0]        rsum;
    logic [32:0]        rq;
    car_e_nxt = car_d_r;
    for (int i = 0; i < 4; i++) begin
      p    = $signed({{7{q_d_r[i][15]}}, q_d_r[i], 31'b0})
           + $signed({{2{m_d_r[i][51]}}, m_d_r[i]});
      pmag = p[53] ? 54'(-p) : 54'(p);
      rsum = pmag + 54'(1 << 20);
      rq   = rsum[53:21];
      car_e_nxt.neg[i] = p[53];
      car_e_nxt.mag[i] = (|rq[32:31]) ? '1 : rq[30:0];
    end
  end

  // front stages: rate correction, products, sums, period scaling, rounding,
  // squares, norm sum
  always_ff @(posedge clk) begin
    if (en) begin
      q_a_r[0] <= in_data.quat_w;
      q_a_r[1] <= in_data.quat_x;
      q_a_r[2] <= in_data.quat_y;
      q_a_r[3] <= in_data.quat_z;
      c_a_r[0] <= 17'(in_data.rate_x) - 17'(in_data.bias_x);
      c_a_r[1] <= 17'(in_data.rate_y) - 17'(in_data.bias_y);
      c_a_r[2] <= 17'(in_data.rate_z) - 17'(in_data.bias_z);
      car_a_r.bias_x <= in_data.bias_x;
      car_a_r.bias_y <= in_data.bias_y;
      car_a_r.bias_z <= in_data.bias_z;
      car_a_r.neg    <= '0;
      car_a_r.mag    <= '0;

      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_b_r[i][j] <= q_a_r[i] * c_a_r[j];
        end
      end
      q_b_r   <= q_a_r;
      car_b_r <= car_a_r;

      // q (x) (0,c)
      s_c_r[0] <= -35'(prod_b_r[1][0]) - 35'(prod_b_r[2][1]) - 35'(prod_b_r[3][2]);
      s_c_r[1] <=  35'(prod_b_r[0][0]) + 35'(prod_b_r[2][2]) - 35'(prod_b_r[3][1]);
      s_c_r[2] <=  35'(prod_b_r[0][1]) - 35'(prod_b_r[1][2]) + 35'(prod_b_r[3][0]);
      s_c_r[3] <=  35'(prod_b_r[0][2]) + 35'(prod_b_r[1][1]) - 35'(prod_b_r[2][0]);
      q_c_r    <= q_b_r;
      car_c_r  <= car_b_r;

      for (int i = 0; i < 4; i++) begin
        m_d_r[i] <= s_c_r[i] * $signed({1'b0, step_period_r});
      end
      q_d_r   <= q_c_r;
      car_d_r <= car_c_r;

      car_e_r <= car_e_nxt;

      for (int i = 0; i < 4; i++) begin
        sq_f_r[i] <= car_e_r.mag[i] * car_e_r.mag[i];
      end
      car_f_r <= car_e_r;

      sr_rem_r[0] <= 64'(sq_f_r[0]) + 64'(sq_f_r[1]) + 64'(sq_f_r[2]) + 64'(sq_f_r[3]);
      sr_res_r[0] <= '0;
      sr_car_r[0] <= car_f_r;
    end
  end

  // integer square root, one result bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    logic        take;
    assign trial = sr_res_r[k] + BIT;
    assign take  = sr_rem_r[k] >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sr_v_r[k+1] <= 1'b0;
      end else if (en) begin
        sr_v_r[k+1] <= sr_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sr_rem_r[k+1] <= take ? sr_rem_r[k] - trial : sr_rem_r[k];
        sr_res_r[k+1] <= take ? (sr_res_r[k] >> 1) + BIT : sr_res_r[k] >> 1;
        sr_car_r[k+1] <= sr_car_r[k];
      end
    end
  end

  // divide setup: rounded numerator |u|*2^14 + r/2
  always_ff @(posedge clk) begin
    logic [31:0] r;
    r = sr_res_r[NS][31:0];
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        dv_rem_r[i][0] <= {1'b0, sr_car_r[NS].mag[i], 14'b0} + 46'(r >> 1);
        dv_quo_r[i][0] <= '0;
      end
      dv_r_r[0]    <= r;
      dv_zero_r[0] <= (r == 32'd0);
      dv_car_r[0]  <= sr_car_r[NS];
    end
  end

  // restoring divide, four lanes, one quotient bit per stage
  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [46:0] dsr;
    logic [3:0]  take;
    assign dsr = 47'(dv_r_r[j]) << (ND - 1 - j);
    for (genvar i = 0; i < 4; i++) begin : g_lane
      assign take[i] = {1'b0, dv_rem_r[i][j]} >= dsr;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 4; i++) begin
          dv_rem_r[i][j+1] <= take[i] ? dv_rem_r[i][j] - dsr[45:0] : dv_rem_r[i][j];
          dv_quo_r[i][j+1] <= {dv_quo_r[i][j][13:0], take[i]};
        end
        dv_r_r[j+1]    <= dv_r_r[j];
        dv_zero_r[j+1] <= dv_zero_r[j];
        dv_car_r[j+1]  <= dv_car_r[j];
      end
    end
  end

  // sign, zero-norm override, output register
  always_comb begin
    logic signed [15:0] n [4];
    logic [15:0]        qz;
    for (int i = 0; i < 4; i++) begin
      qz = {1'b0, dv_quo_r[i][ND]};
      if (dv_zero_r[ND]) begin
        n[i] = '0;
      end else begin
        n[i] = dv_car_r[ND].neg[i] ? $signed(-qz) : $signed(qz);
      end
    end
    out_item_nxt.next_w     = n[0];
    out_item_nxt.next_x     = n[1];
    out_item_nxt.next_y     = n[2];
    out_item_nxt.next_z     = n[3];
    out_item_nxt.bias_out_x = dv_car_r[ND].bias_x;
    out_item_nxt.bias_out_y = dv_car_r[ND].bias_y;
    out_item_nxt.bias_out_z = dv_car_r[ND].bias_z;
    out_item_nxt.zero_norm  = dv_zero_r[ND];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule
`default_nettype wire
